// ===== design/mctp_tx_pkg.sv =====
// Shared types and constants of the MCTP transmit packetizer.
`timescale 1ns / 1ps

package mctp_tx_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int JOBQ_DEPTH_DEFAULT = 4;

  localparam logic [7:0] HDR_VERSION = 8'h01;
  localparam logic [2:0] TAG_LIMIT = 3'h7;

  localparam logic [7:0] LOCAL_EP_RESET = 8'd8;
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd64;

  localparam logic REG_LOCAL_EP = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] message_length;
    logic [7:0]  dest_endpoint;
    logic        owner_flag;
    logic        bridge_mode;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_last;
  } out_item_t;

  // One classified input byte, ready for the back end to send.
  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic [7:0] dest;
    logic [7:0] flags;
    logic       pend;
  } job_t;

endpackage

// ===== design/mctp_tx_packetizer_unit.sv =====
// Top level of the MCTP transmit packetizer.
`timescale 1ns / 1ps

// Message bytes come in one word per cycle through push/full. The front end
// tracks the open message (bytes left, packet fill, sequence, SOM, tag) and
// classifies each byte into a job: a payload byte, optionally preceded by a
// four-byte transport header when it opens a packet. Jobs wait in a short
// queue (JOBQ_DEPTH entries); the back end expands each job into output words
// and holds the oldest one in a registered result stage read through
// empty/pop. Output runs at one word per cycle while the receiver pops: a
// byte that opens a packet expands into five output words, every other byte
// into one, so the input side stalls (full) only when header insertion or a
// held-off receiver has filled the queue. The first word caused by a byte
// passes the queue slot and then the result register before it shows up at
// the result port. Bridged messages skip the header and pass through byte for
// byte; bytes with no message open, and zero-length starts, produce no word.
// Write the configuration registers only while the block is idle; the
// header's source endpoint is taken live from the register.

module mctp_tx_packetizer_unit
  import mctp_tx_pkg::*;
#(
  parameter int JOBQ_DEPTH = JOBQ_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_item_t   item,
  output logic       empty,
  input  logic       pop,
  output out_item_t  result,
  input  logic       wr_en,
  input  logic       wr_index,
  input  logic [7:0] wr_data
);

  logic [7:0] local_endpoint;
  logic [7:0] max_payload;

  logic accept;
  logic jq_push;
  job_t jq_in;
  logic jq_pop;
  logic jq_valid;
  job_t jq_head;
  logic out_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      local_endpoint <= LOCAL_EP_RESET;
      max_payload    <= MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_LOCAL_EP:    local_endpoint <= wr_data;
        REG_MAX_PAYLOAD: max_payload    <= wr_data;
        default:         ;
      endcase
    end
  end

  // Take a word whenever the job queue has room.
  assign accept = push && !full;
  assign empty  = !out_valid;

  mctp_tx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .max_payload (max_payload),
    .push_en     (jq_push),
    .job         (jq_in)
  );

  mctp_tx_jobq #(
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push_en  (jq_push),
    .push_job (jq_in),
    .pop_en   (jq_pop),
    .full     (full),
    .valid    (jq_valid),
    .head     (jq_head)
  );

  mctp_tx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (jq_valid),
    .job            (jq_head),
    .job_pop        (jq_pop),
    .local_endpoint (local_endpoint),
    .pop            (pop),
    .out_valid      (out_valid),
    .result         (result)
  );

endmodule

// ===== design/mctp_tx_front.sv =====
// Front end: message/packet state tracking and classification of each input byte.
`timescale 1ns / 1ps

module mctp_tx_front
  import mctp_tx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  in_item_t   item,
  input  logic [7:0] max_payload,
  output logic       push_en,
  output job_t       job
);

  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [7:0]  packet_fill, packet_fill_next;
  logic [1:0]  packet_seq, packet_seq_next;
  logic        first_packet, first_packet_next;
  logic [2:0]  message_tag, message_tag_next;
  logic [7:0]  held_dest, held_dest_next;
  logic        held_owner, held_owner_next;
  logic        held_bridge, held_bridge_next;

  always_comb begin
    logic [7:0]  limit;
    logic [15:0] br_eff;
    logic [7:0]  fill_eff;
    logic [1:0]  seq_eff;
    logic        fp_eff;
    logic        eom;
    logic        last_of_msg;
    logic [3:0]  tag_inc;

    bytes_remaining_next = bytes_remaining;
    packet_fill_next     = packet_fill;
    packet_seq_next      = packet_seq;
    first_packet_next    = first_packet;
    message_tag_next     = message_tag;
    held_dest_next       = held_dest;
    held_owner_next      = held_owner;
    held_bridge_next     = held_bridge;
    push_en              = 1'b0;
    job                  = '0;

    limit       = (max_payload == 8'd0) ? 8'd1 : max_payload;
    br_eff      = item.first_byte ? item.message_length : bytes_remaining;
    fill_eff    = item.first_byte ? 8'd0 : packet_fill;
    seq_eff     = item.first_byte ? 2'd0 : packet_seq;
    fp_eff      = item.first_byte ? 1'b1 : first_packet;
    last_of_msg = (br_eff == 16'd1);
    eom         = (br_eff <= {8'd0, limit});
    tag_inc     = {1'b0, message_tag} + 4'd1;

    if (accept) begin
      if (item.first_byte && item.message_length == 16'd0) begin
        // zero-length start: close whatever was open, send nothing
        bytes_remaining_next = 16'd0;
      end else begin
        if (item.first_byte) begin
          held_dest_next   = item.dest_endpoint;
          held_owner_next  = item.owner_flag;
          held_bridge_next = item.bridge_mode;
        end
        packet_fill_next  = fill_eff;
        packet_seq_next   = seq_eff;
        first_packet_next = fp_eff;
        if (br_eff != 16'd0) begin
          push_en              = 1'b1;
          bytes_remaining_next = br_eff - 16'd1;
          job.data             = item.data_byte;
          if (held_bridge_next) begin
            job.pend = last_of_msg;
          end else begin
            job.hdr   = (fill_eff == 8'd0);
            job.dest  = held_dest_next;
            job.flags = {fp_eff, eom, seq_eff, held_owner_next, message_tag};
            job.pend  = last_of_msg || ({1'b0, fill_eff} + 9'd1 >= {1'b0, limit});
            if (job.pend) begin
              packet_fill_next  = 8'd0;
              packet_seq_next   = seq_eff + 2'd1;
              first_packet_next = 1'b0;
            end else begin
              packet_fill_next = fill_eff + 8'd1;
            end
            if (last_of_msg) begin
              message_tag_next = (tag_inc[2:0] >= TAG_LIMIT || tag_inc[3]) ? 3'd0 :
                                 tag_inc[2:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 16'd0;
      packet_fill     <= 8'd0;
      packet_seq      <= 2'd0;
      first_packet    <= 1'b1;
      message_tag     <= 3'd0;
      held_dest       <= 8'd0;
      held_owner      <= 1'b0;
      held_bridge     <= 1'b0;
    end else begin
      bytes_remaining <= bytes_remaining_next;
      packet_fill     <= packet_fill_next;
      packet_seq      <= packet_seq_next;
      first_packet    <= first_packet_next;
      message_tag     <= message_tag_next;
      held_dest       <= held_dest_next;
      held_owner      <= held_owner_next;
      held_bridge     <= held_bridge_next;
    end
  end

endmodule

// ===== design/mctp_tx_jobq.sv =====
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module mctp_tx_jobq
  import mctp_tx_pkg::*;
#(
  parameter int DEPTH = JOBQ_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push_en,
  input  job_t push_job,
  input  logic pop_en,
  output logic full,
  output logic valid,
  output job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_en) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push_en && !pop_en) begin
        count <= count + CW'(1);
      end else if (pop_en && !push_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== design/mctp_tx_back.sv =====
// Back end: header expansion and the registered result word.
`timescale 1ns / 1ps

module mctp_tx_back
  import mctp_tx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  input  logic [7:0] local_endpoint,
  input  logic       pop,
  output logic       out_valid,
  output out_item_t  result
);

  localparam int PHW = $clog2(HEADER_BYTES + 1);

  logic [PHW-1:0] phase, phase_next;
  logic           advance;
  logic           emit;
  out_item_t      word_next;

  assign advance = !out_valid || pop;

  always_comb begin
    phase_next = phase;
    job_pop    = 1'b0;
    emit       = 1'b0;
    word_next  = '0;
    if (job_valid && advance) begin
      emit = 1'b1;
      if (job.hdr && phase != PHW'(HEADER_BYTES)) begin
        phase_next = phase + PHW'(1);
        case (phase)
          PHW'(0): word_next.out_byte = HDR_VERSION;
          PHW'(1): word_next.out_byte = job.dest;
          PHW'(2): word_next.out_byte = local_endpoint;
          default: word_next.out_byte = job.flags;
        endcase
      end else begin
        job_pop              = 1'b1;
        phase_next           = '0;
        word_next.out_byte   = job.data;
        word_next.packet_end = job.pend;
        word_next.run_last   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= '0;
    end else begin
      phase <= phase_next;
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= word_next;
    end
  end

  // Mid-header the job must stay at the queue head.
  a_phase_holds_job: assert property (@(posedge clk) disable iff (rst)
    phase != '0 |-> job_valid)
    else $error("header phase active with no job");

  // Header bytes never close a packet.
  a_hdr_no_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.run_last |-> !result.packet_end)
    else $error("packet end on a header byte");

  // A header sequence opens at phase zero and steps by one.
  a_hdr_step: assert property (@(posedge clk) disable iff (rst)
    emit && !job_pop |=> phase == $past(phase) + PHW'(1))
    else $error("header phase did not advance");

endmodule
